// ===== rtl/core/lpml_pkg.sv =====
// ============================================================================
// lpml_pkg: Shared types for the longest-prefix-match lookup
// Request and response payloads, the stored route format and the sequencer
// states.
// ============================================================================
package lpml_pkg;

    localparam int ADDR_W = 32;
    localparam int LEN_W = 6;
    localparam int HOP_W = 8;
    localparam int SLOT_W = 3;
    localparam logic [LEN_W-1:0] PREFIX_MAX = 6'd32;

    typedef enum logic {
        REQ_LOOKUP = 1'b0,
        REQ_WRITE  = 1'b1
    } lpml_req_kind_t;

    typedef struct packed {
        logic              req_type;
        logic [SLOT_W-1:0] entry_index;
        logic [ADDR_W-1:0] entry_network;
        logic [LEN_W-1:0]  entry_mask_len;
        logic [HOP_W-1:0]  entry_hop;
        logic              entry_valid;
        logic [ADDR_W-1:0] dest_address;
    } lpml_req_t;

    typedef struct packed {
        logic             write_ack;
        logic             hop_found;
        logic [HOP_W-1:0] hop_code;
        logic [LEN_W-1:0] matched_len;
    } lpml_rsp_t;

    typedef struct packed {
        logic [ADDR_W-1:0] network;
        logic [LEN_W-1:0]  mask_len;
        logic [HOP_W-1:0]  hop;
    } lpml_route_t;

    typedef struct packed {
        logic hit;
        logic better;
    } lpml_match_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESULT
    } lpml_state_t;

endpackage

// ===== rtl/core/lpml_req_if.sv =====
// ============================================================================
// lpml_req_if: Request channel
// Valid/ready channel that carries one lookup or table write item.
// ============================================================================
interface lpml_req_if;
    import lpml_pkg::*;

    logic      valid;
    logic      ready;
    lpml_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/lpml_rsp_if.sv =====
// ============================================================================
// lpml_rsp_if: Response channel
// Valid/ready channel that carries one result item.
// ============================================================================
interface lpml_rsp_if;
    import lpml_pkg::*;

    logic      valid;
    logic      ready;
    lpml_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/core/longest_prefix_match_lookup_top.sv =====
// ============================================================================
// longest_prefix_match_lookup_top: IPv4 longest-prefix-match routing table
// Stores routes and answers lookups with the next hop of the longest match.
// ============================================================================
// A write item is stored on acceptance, and its acknowledge is loaded into
// the output register from the result state once that register is free. A
// lookup item is accepted and starts the first table read; then the single RAM
// read port and the single prefix comparator walk the table in index order,
// one route per cycle, and the result state issues the result once the output
// register is free. The request channel is not ready while an item is in work.
// A finished result sits in an output register, so the next request is taken
// while the previous result waits. Route valid bits are flip-flops that reset
// clears, so the table is empty right after reset with no clearing pass.
// Writes to a slot at or beyond TABLE_ENTRIES are acknowledged and dropped.
module longest_prefix_match_lookup_top #(
    parameter int TABLE_ENTRIES = 8
) (
    input logic         clk,
    input logic         rst_n,
    lpml_req_if.sink    req,
    lpml_rsp_if.source  rsp
);
    import lpml_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ROUTE_W = $bits(lpml_route_t);

    lpml_state_t        state_reg;
    lpml_state_t        state_next;
    logic [IDX_W-1:0]   scan_idx_reg;
    logic [IDX_W-1:0]   scan_idx_next;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic               write_reg;
    logic [ADDR_W-1:0]  dest_reg;
    logic               best_found_reg;
    logic [LEN_W-1:0]   best_len_reg;
    logic [HOP_W-1:0]   best_hop_reg;
    logic               out_valid_reg;
    lpml_rsp_t          out_reg;

    logic               accept;
    logic               start;
    logic               load_out;
    logic               wr_en;
    logic               in_range;
    logic [IDX_W-1:0]   wr_addr;
    logic [IDX_W-1:0]   rd_addr;
    logic [LEN_W-1:0]   len_sat;
    lpml_route_t        wr_route;
    logic [ROUTE_W-1:0] rd_data;
    lpml_route_t        rd_route;
    lpml_match_t        match;

    assign accept = req.valid && req.ready;
    assign in_range = (7'(req.payload.entry_index) < 7'(TABLE_ENTRIES));
    assign wr_en = accept && (req.payload.req_type == REQ_WRITE) && in_range;
    assign wr_addr = IDX_W'(req.payload.entry_index);
    assign len_sat = (req.payload.entry_mask_len > PREFIX_MAX) ? PREFIX_MAX
                                                               : req.payload.entry_mask_len;
    assign wr_route = '{network: req.payload.entry_network,
                        mask_len: len_sat,
                        hop: req.payload.entry_hop};
    assign rd_route = lpml_route_t'(rd_data);

    lpml_ram #(
        .WIDTH(ROUTE_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_route_ram (
        .clk(clk),
        .wr_en(wr_en),
        .wr_addr(wr_addr),
        .wr_data(ROUTE_W'(wr_route)),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    lpml_match u_match (
        .dest(dest_reg),
        .route(rd_route),
        .route_valid(valid_reg[scan_idx_reg]),
        .best_found(best_found_reg),
        .best_len(best_len_reg),
        .result(match)
    );

    always_comb
    begin
        state_next = state_reg;
        scan_idx_next = scan_idx_reg;
        rd_addr = scan_idx_reg + IDX_W'(1);
        req.ready = 1'b0;
        start = 1'b0;
        load_out = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
                rd_addr = '0;
                if (req.valid)
                begin
                    start = 1'b1;
                    scan_idx_next = '0;
                    state_next = (req.payload.req_type == REQ_WRITE) ? ST_RESULT : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                scan_idx_next = scan_idx_reg + IDX_W'(1);
                if (scan_idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    load_out = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            scan_idx_reg <= '0;
            valid_reg <= '0;
            out_valid_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            scan_idx_reg <= scan_idx_next;
            if (wr_en)
            begin
                valid_reg[wr_addr] <= req.payload.entry_valid;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (start)
            begin
                best_found_reg <= 1'b0;
            end
            else if ((state_reg == ST_SCAN) && match.better)
            begin
                best_found_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            write_reg <= req.payload.req_type;
            dest_reg <= req.payload.dest_address;
            best_len_reg <= '0;
            best_hop_reg <= '0;
        end
        else if ((state_reg == ST_SCAN) && match.better)
        begin
            best_len_reg <= rd_route.mask_len;
            best_hop_reg <= rd_route.hop;
        end
        if (load_out)
        begin
            out_reg.write_ack <= write_reg;
            out_reg.hop_found <= best_found_reg;
            out_reg.hop_code <= best_hop_reg;
            out_reg.matched_len <= best_len_reg;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.payload = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("Request accepted while an item was still in work.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.payload.write_ack) |->
            (!rsp.payload.hop_found && (rsp.payload.hop_code == '0)
             && (rsp.payload.matched_len == '0)))
        else $error("Write acknowledge carries lookup data.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.payload.hop_found) |->
            ((rsp.payload.hop_code == '0) && (rsp.payload.matched_len == '0)))
        else $error("Miss result carries a hop or a length.");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.payload.matched_len <= PREFIX_MAX))
        else $error("Matched length exceeds the address width.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESULT && out_valid_reg && !rsp.ready) |=> (state_reg == ST_RESULT))
        else $error("Result dropped while the output register was full.");
endmodule

// ===== rtl/core/lpml_ram.sv =====
// ============================================================================
// lpml_ram: Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ============================================================================
module lpml_ram #(
    parameter int WIDTH = 46,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== rtl/core/lpml_match.sv =====
// ============================================================================
// lpml_match: Shared prefix comparator
// Compares the leading bits of the destination with one route and decides
// whether that route beats the best match found so far.
// ============================================================================
module lpml_match (
    input  logic [lpml_pkg::ADDR_W-1:0] dest,
    input  lpml_pkg::lpml_route_t       route,
    input  logic                        route_valid,
    input  logic                        best_found,
    input  logic [lpml_pkg::LEN_W-1:0]  best_len,
    output lpml_pkg::lpml_match_t       result
);
    import lpml_pkg::*;

    logic [ADDR_W-1:0] mask;

    // Shifting all ones right by the length leaves exactly the host bits set.
    assign mask = ~({ADDR_W{1'b1}} >> route.mask_len);

    always_comb
    begin
        result.hit = route_valid && (((dest ^ route.network) & mask) == '0);
        result.better = result.hit && (!best_found || (route.mask_len > best_len));
    end
endmodule

// ===== tb/route_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// route_checker: Result checker for the longest-prefix-match lookup
// Watches the request and result channels. Keeps its own copy of the route
// table, works out the expected result of every accepted request, and
// compares each accepted result field by field with the oldest expected one.
// ============================================================================
module route_checker #(
    parameter int SLOTS = 8
) (
    input  logic clk,
    input  logic rst_n,
    lpml_req_if  req,
    lpml_rsp_if  rsp,
    output int   pending_results,
    output int   error_count
);
    import lpml_pkg::*;

    logic [ADDR_W-1:0] fib_net   [SLOTS];
    logic [LEN_W-1:0]  fib_len   [SLOTS];
    logic [HOP_W-1:0]  fib_hop   [SLOTS];
    logic              fib_valid [SLOTS];

    lpml_rsp_t route_rsp_q[$];

    function automatic lpml_rsp_t apply_route_request(input lpml_req_t r);
        lpml_rsp_t         res;
        logic [ADDR_W-1:0] mask;
        res = '0;
        if (r.req_type == REQ_WRITE)
        begin
            res.write_ack = 1'b1;
            if (int'(r.entry_index) < SLOTS)
            begin
                fib_net[r.entry_index]   = r.entry_network;
                fib_len[r.entry_index]   = (r.entry_mask_len > PREFIX_MAX) ?
                                           PREFIX_MAX : r.entry_mask_len;
                fib_hop[r.entry_index]   = r.entry_hop;
                fib_valid[r.entry_index] = r.entry_valid;
            end
        end
        else
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                if (fib_valid[i])
                begin
                    mask = (fib_len[i] == '0) ? '0
                                              : (~32'h0) << (ADDR_W - int'(fib_len[i]));
                    if (((r.dest_address ^ fib_net[i]) & mask) == '0 &&
                        (!res.hop_found || fib_len[i] > res.matched_len))
                    begin
                        res.hop_found   = 1'b1;
                        res.matched_len = fib_len[i];
                        res.hop_code    = fib_hop[i];
                    end
                end
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0h, actual %0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk)
    begin : monitor
        lpml_rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                fib_net[i]   = '0;
                fib_len[i]   = '0;
                fib_hop[i]   = '0;
                fib_valid[i] = 1'b0;
            end
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (route_rsp_q.size() == 0)
                begin
                    $error("Result item arrived with no request outstanding.");
                    error_count++;
                end
                else
                begin
                    want = route_rsp_q.pop_front();
                    check_field("write_ack", 32'(want.write_ack),
                                32'(rsp.payload.write_ack));
                    check_field("hop_found", 32'(want.hop_found),
                                32'(rsp.payload.hop_found));
                    check_field("hop_code", 32'(want.hop_code),
                                32'(rsp.payload.hop_code));
                    check_field("matched_len", 32'(want.matched_len),
                                32'(rsp.payload.matched_len));
                end
            end
            if (req.valid && req.ready)
            begin
                route_rsp_q.push_back(apply_route_request(req.payload));
            end
        end
        pending_results <= route_rsp_q.size();
    end

endmodule

// ===== tb/longest_prefix_match_lookup_top_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// longest_prefix_match_lookup_top_tb: Testbench for the routing table lookup
// Writes routes and looks up destinations: a directed sequence first, then
// random items biased toward nested, tied and removed prefixes, under three
// patterns of idle cycles on both channels. A separate checker judges results.
// ============================================================================
module longest_prefix_match_lookup_top_tb;
    import lpml_pkg::*;

    localparam int ROUTE_SLOTS = 8;

    logic clk;
    logic rst_n;
    int   pending_results;
    int   error_count;
    int   snd_idle_pct;
    int   rcv_idle_pct;

    bit [ADDR_W-1:0] known_net [ROUTE_SLOTS];
    int              known_len [ROUTE_SLOTS];

    lpml_req_if req_ch ();
    lpml_rsp_if rsp_ch ();

    longest_prefix_match_lookup_top #(
        .TABLE_ENTRIES(ROUTE_SLOTS)
    ) uut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    route_checker #(
        .SLOTS(ROUTE_SLOTS)
    ) u_route_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .pending_results(pending_results),
        .error_count    (error_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL longest_prefix_match_lookup_top");
        $finish;
    end

    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    function automatic lpml_req_t random_request();
        lpml_req_t r;
        r.req_type         = 1'($urandom_range(1));
        r.entry_index      = SLOT_W'($urandom_range(ROUTE_SLOTS - 1));
        r.entry_network    = $urandom();
        r.entry_mask_len   = LEN_W'($urandom_range(63));
        r.entry_hop        = HOP_W'($urandom_range(255));
        r.entry_valid      = 1'($urandom_range(1));
        r.dest_address     = $urandom();
        return r;
    endfunction

    task automatic send_item(input lpml_req_t item);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= item;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
    endtask

    task automatic write_route(input int idx, input logic [ADDR_W-1:0] net,
                               input logic [LEN_W-1:0] len, input logic [HOP_W-1:0] hop,
                               input logic live);
        lpml_req_t item;
        item                  = random_request();
        item.req_type         = REQ_WRITE;
        item.entry_index      = SLOT_W'(idx);
        item.entry_network    = net;
        item.entry_mask_len   = len;
        item.entry_hop        = hop;
        item.entry_valid      = live;
        known_net[idx]        = net;
        known_len[idx]        = (len > PREFIX_MAX) ? 32 : int'(len);
        send_item(item);
    endtask

    task automatic lookup_route(input logic [ADDR_W-1:0] dest);
        lpml_req_t item;
        item              = random_request();
        item.req_type     = REQ_LOOKUP;
        item.dest_address = dest;
        send_item(item);
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
    endtask

    task automatic run_random_items(input int count);
        int              j;
        int              kind;
        int              deeper;
        logic [ADDR_W-1:0] net;
        logic [LEN_W-1:0]  len;
        for (int n = 0; n < count; n++)
        begin
            j = $urandom_range(ROUTE_SLOTS - 1);
            if ($urandom_range(99) < 30)
            begin
                kind = $urandom_range(9);
                net  = $urandom();
                len  = LEN_W'($urandom_range(32));
                if (kind >= 4 && kind <= 6)
                begin
                    deeper = known_len[j] + int'($urandom_range(8));
                    len    = (deeper > 32) ? 6'd32 : LEN_W'(deeper);
                    net    = known_net[j] ^ (32'($urandom()) >> known_len[j]);
                end
                else if (kind == 7)
                begin
                    net = known_net[j];
                    len = LEN_W'(known_len[j]);
                end
                else if (kind == 8)
                begin
                    len = LEN_W'($urandom_range(63, 33));
                end
                write_route($urandom_range(ROUTE_SLOTS - 1), net, len,
                            HOP_W'($urandom_range(255)), $urandom_range(9) != 0);
            end
            else
            begin
                kind = $urandom_range(99);
                net  = $urandom();
                if (kind < 60)
                begin
                    net = known_net[j] ^ (net >> known_len[j]);
                end
                else if (kind < 75 && known_len[j] != 0)
                begin
                    net = known_net[j] ^ (32'h8000_0000 >> $urandom_range(known_len[j] - 1));
                end
                lookup_route(net);
            end
        end
    endtask

    initial
    begin
        snd_idle_pct = 22;
        rcv_idle_pct = 76;
        rst_n          <= 1'b0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        lookup_route(32'h0000_0000);
        lookup_route(32'hFFFF_FFFF);
        write_route(0, 32'h0000_0000, 6'd0, 8'h11, 1'b1);
        lookup_route(32'h5A5A_A5A5);
        write_route(7, 32'hFFFF_FFFF, 6'd32, 8'hFF, 1'b1);
        lookup_route(32'hFFFF_FFFF);
        lookup_route(32'hFFFF_FFFE);
        write_route(3, 32'h0A00_0000, 6'd8, 8'h0A, 1'b1);
        write_route(2, 32'h0A00_0000, 6'd8, 8'h0B, 1'b1);
        lookup_route(32'h0A12_3456);
        write_route(5, 32'hC0A8_0000, 6'd63, 8'h55, 1'b1);
        lookup_route(32'hC0A8_0000);
        lookup_route(32'hC0A8_0001);
        write_route(2, 32'h0A00_0000, 6'd8, 8'hEE, 1'b0);
        lookup_route(32'h0A00_0001);
        write_route(4, 32'h0A80_0000, 6'd9, 8'h44, 1'b1);
        lookup_route(32'h0A80_0000);
        write_route(0, 32'h0000_0000, 6'd0, 8'h11, 1'b0);
        lookup_route(32'h1234_5678);
        write_route(6, 32'h8000_0000, 6'd1, 8'h81, 1'b1);
        lookup_route(32'h8000_0000);
        lookup_route(32'h7FFF_FFFF);
        write_route(1, 32'h1234_5678, 6'd33, 8'h00, 1'b1);
        lookup_route(32'h1234_5678);
        wait_drained();

        run_random_items(542);
        wait_drained();

        snd_idle_pct = 76;
        rcv_idle_pct = 22;
        run_random_items(542);
        wait_drained();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        run_random_items(542);
        wait_drained();
        repeat (24) @(posedge clk);

        if (error_count == 0)
        begin
            $display("PASS longest_prefix_match_lookup_top");
        end
        else
        begin
            $display("FAIL longest_prefix_match_lookup_top");
        end
        $finish;
    end

endmodule
